// File: rtl/core/ipa_pkg.sv
// Shared types and constants of the instruction parcel aligner.
`timescale 1ns / 1ps
`default_nettype none

package ipa_pkg;

  // Word address width; halfword addresses carry one more bit.
  localparam int WORD_ADDR_BITS = 16;
  localparam int HALF_ADDR_BITS = WORD_ADDR_BITS + 1;
  localparam int OUT_ADDR_BITS  = 17;

  localparam int WORD_BITS   = 32;
  localparam int PARCEL_BITS = 16;
  localparam int INSTR_BITS  = 32;

  // Low two bits of a parcel that open a 32-bit instruction.
  localparam logic [1:0] OPEN32_CODE = 2'b11;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Output payload: instr, then halfword_addr, padded to whole bytes.
  localparam int OUT_DATA_BITS = ((INSTR_BITS + OUT_ADDR_BITS + 7) / 8) * 8;

  typedef logic [WORD_ADDR_BITS-1:0] word_idx_t;
  typedef logic [HALF_ADDR_BITS-1:0] half_addr_t;
  typedef logic [OUT_ADDR_BITS-1:0]  out_addr_t;

  // One classified word: a first result and an optional second one.
  typedef struct packed {
    logic [INSTR_BITS-1:0]  first_instr;
    logic                   first_comp;
    out_addr_t              first_addr;
    logic                   has_second;
    logic [PARCEL_BITS-1:0] second_parcel;
    out_addr_t              second_addr;
  } ipa_entry_t;

  // Map an internal halfword address onto the 17-bit output field.
  function automatic out_addr_t to_out_addr(input half_addr_t a);
    logic [HALF_ADDR_BITS+OUT_ADDR_BITS-1:0] ext;
    ext = (HALF_ADDR_BITS + OUT_ADDR_BITS)'(a);
    return ext[OUT_ADDR_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ipa_front.sv
// Front end: accepts fetched words, splits them into parcels, tracks the address.
`timescale 1ns / 1ps
`default_nettype none

module ipa_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              word_valid,
  input  wire logic [ipa_pkg::WORD_BITS-1:0]     word,
  input  wire logic                              push_ready,
  output      logic                              push_valid,
  output      ipa_pkg::ipa_entry_t               push_entry
);

  logic                              pend_valid_r, pend_valid_nxt;
  logic [ipa_pkg::PARCEL_BITS-1:0]   pend_parcel_r, pend_parcel_nxt;
  ipa_pkg::word_idx_t                word_idx_r, word_idx_nxt;

  logic [ipa_pkg::PARCEL_BITS-1:0]   lo, hi;
  ipa_pkg::half_addr_t               base;
  logic                              fire;

  assign lo         = word[ipa_pkg::PARCEL_BITS-1:0];
  assign hi         = word[ipa_pkg::WORD_BITS-1:ipa_pkg::PARCEL_BITS];
  assign base       = {word_idx_r, 1'b0};
  assign push_valid = word_valid;
  assign fire       = word_valid && push_ready;

  // Classify the word against the pending parcel
  always_comb begin
    push_entry                = '0;
    push_entry.second_parcel  = hi;
    push_entry.second_addr    = ipa_pkg::to_out_addr({word_idx_r, 1'b1});
    pend_valid_nxt            = pend_valid_r;
    pend_parcel_nxt           = pend_parcel_r;
    word_idx_nxt              = word_idx_r;

    if (pend_valid_r) begin
      // straddling instruction starts one halfword before this word
      push_entry.first_instr = {lo, pend_parcel_r};
      push_entry.first_comp  = 1'b0;
      push_entry.first_addr  = ipa_pkg::to_out_addr(base - 1'b1);
    end else if (lo[1:0] == ipa_pkg::OPEN32_CODE) begin
      push_entry.first_instr = word;
      push_entry.first_comp  = 1'b0;
      push_entry.first_addr  = ipa_pkg::to_out_addr(base);
    end else begin
      push_entry.first_instr = {{ipa_pkg::PARCEL_BITS{1'b0}}, lo};
      push_entry.first_comp  = 1'b1;
      push_entry.first_addr  = ipa_pkg::to_out_addr(base);
    end

    // upper half: second compressed result, held as pending low half, or part of a whole-word instruction
    if (!pend_valid_r && lo[1:0] == ipa_pkg::OPEN32_CODE) begin
      push_entry.has_second = 1'b0;
    end else if (hi[1:0] == ipa_pkg::OPEN32_CODE) begin
      push_entry.has_second = 1'b0;
    end else begin
      push_entry.has_second = 1'b1;
    end

    if (fire) begin
      word_idx_nxt = word_idx_r + 1'b1;
      if (!pend_valid_r && lo[1:0] == ipa_pkg::OPEN32_CODE) begin
        pend_valid_nxt = 1'b0;
      end else if (hi[1:0] == ipa_pkg::OPEN32_CODE) begin
        pend_valid_nxt  = 1'b1;
        pend_parcel_nxt = hi;
      end else begin
        pend_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r  <= 1'b0;
      pend_parcel_r <= '0;
      word_idx_r    <= '0;
    end else begin
      pend_valid_r  <= pend_valid_nxt;
      pend_parcel_r <= pend_parcel_nxt;
      word_idx_r    <= word_idx_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ipa_queue.sv
// Short queue of classified words between front and back.
`timescale 1ns / 1ps
`default_nettype none

module ipa_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  input  wire ipa_pkg::ipa_entry_t  push_entry,
  output      logic                 push_ready,
  output      logic                 pop_valid,
  input  wire logic                 pop_ready,
  output      ipa_pkg::ipa_entry_t  pop_entry
);

  ipa_pkg::ipa_entry_t              mem_r [ipa_pkg::QUEUE_DEPTH];
  logic [ipa_pkg::QPTR_BITS-1:0]    wr_ptr_r, rd_ptr_r;
  logic [ipa_pkg::QCNT_BITS-1:0]    count_r;
  logic                             do_push, do_pop;

  assign push_ready = (count_r != ipa_pkg::QCNT_BITS'(ipa_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == ipa_pkg::QPTR_BITS'(ipa_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == ipa_pkg::QPTR_BITS'(ipa_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ipa_back.sv
// Back end: drains classified words and emits one instruction per transfer.
`timescale 1ns / 1ps
`default_nettype none

module ipa_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  pop_valid,
  input  wire ipa_pkg::ipa_entry_t                   pop_entry,
  output      logic                                  pop_ready,
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      logic [ipa_pkg::INSTR_BITS-1:0]        out_instr,
  output      logic                                  out_comp,
  output      ipa_pkg::out_addr_t                    out_addr,
  output      logic                                  out_last
);

  ipa_pkg::ipa_entry_t  ent_r;
  logic                 ent_valid_r;
  logic                 second_r;   // now showing the second result
  logic                 fire;

  assign out_valid = ent_valid_r;
  assign out_last  = second_r || !ent_r.has_second;
  assign fire      = out_valid && out_ready;
  assign pop_ready = !ent_valid_r || (fire && out_last);

  // Result select from the held entry
  always_comb begin
    if (second_r) begin
      out_instr = {{ipa_pkg::PARCEL_BITS{1'b0}}, ent_r.second_parcel};
      out_comp  = 1'b1;
      out_addr  = ent_r.second_addr;
    end else begin
      out_instr = ent_r.first_instr;
      out_comp  = ent_r.first_comp;
      out_addr  = ent_r.first_addr;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      ent_r <= pop_entry;
    end
  end

  // Entry control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else if (pop_valid && pop_ready) begin
      ent_valid_r <= 1'b1;
      second_r    <= 1'b0;
    end else if (fire && out_last) begin
      ent_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else if (fire) begin
      second_r    <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/instruction_parcel_aligner.sv
// Top level of the instruction parcel aligner.
//
// Input channel (in_*): one fetched 32-bit memory word per transfer, in
// ascending word address order starting at word address zero after reset.
// Output channel (out_*): aligned instructions, one per transfer. A word
// yields one or two instructions; a 32-bit instruction that starts in the
// upper half of a word comes out with the next word. out_tlast marks the
// final instruction caused by an input word.
// A word accepted at the input passes through the queue and then the back end
// entry register before its first instruction shows on out_tvalid.
// Throughput: one word per cycle for one-result words while out_tready is high; a
// two-result word holds the single output port of the back end for both results.
// Reset clears the pending parcel, the word address and the two-entry queue.
// When the receiver stalls, the output holds; the queue keeps taking words
// until both entries are full, then in_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module instruction_parcel_aligner (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output      logic                                 in_tready,
  input  wire logic [ipa_pkg::WORD_BITS-1:0]        in_tdata,   // word
  output      logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  output      logic [ipa_pkg::OUT_DATA_BITS-1:0]    out_tdata,  // instr, halfword_addr, zeros
  output      logic                                 out_tuser,  // is_compressed
  output      logic                                 out_tlast   // last
);

  logic                               push_valid, push_ready;
  ipa_pkg::ipa_entry_t                push_entry, pop_entry;
  logic                               pop_valid, pop_ready;
  logic [ipa_pkg::INSTR_BITS-1:0]     out_instr;
  ipa_pkg::out_addr_t                 out_addr;

  assign in_tready = push_ready;

  ipa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (in_tvalid),
    .word       (in_tdata),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  ipa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  ipa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_instr  (out_instr),
    .out_comp   (out_tuser),
    .out_addr   (out_addr),
    .out_last   (out_tlast)
  );

  // Pack instr and halfword address, zero fill to whole bytes
  assign out_tdata = ipa_pkg::OUT_DATA_BITS'({out_addr, out_instr});

endmodule

`default_nettype wire

// File: bench/instruction_parcel_aligner_tb.sv
// Self-checking bench for the instruction parcel aligner: word stream in, checked instructions out.
`timescale 1ns / 1ps

module instruction_parcel_aligner_tb;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_WORDS   = 400;
  localparam int BURST_LEN      = 40;
  localparam int MAX_CYCLES     = 1_000_000;
  localparam int TAIL_CYCLES    = 20;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AT_RESULT = 80;

  // One fetched word and the idle cycles that follow its transfer
  typedef struct packed {
    logic [ipa_pkg::WORD_BITS-1:0] word;
    logic [3:0]                    gap;
  } fetch_item_t;

  // One aligned instruction as it should leave the block
  typedef struct packed {
    logic [ipa_pkg::INSTR_BITS-1:0] instr;
    logic                           is_comp;
    ipa_pkg::out_addr_t             addr;
    logic                           last;
  } aligned_instr_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [ipa_pkg::WORD_BITS-1:0]     in_tdata   = '0;   // word
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [ipa_pkg::OUT_DATA_BITS-1:0] out_tdata;         // instr, halfword_addr, zeros
  logic                              out_tuser;         // is_compressed
  logic                              out_tlast;         // last

  instruction_parcel_aligner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Words waiting to be sent, instructions waiting to come out
  fetch_item_t    fetch_words[$];
  aligned_instr_t expected_instrs[$];

  // Shadow of the aligner state
  logic                            held_valid  = 1'b0;
  logic [ipa_pkg::PARCEL_BITS-1:0] held_parcel = '0;
  ipa_pkg::word_idx_t              fetch_index = '0;

  // Transfer flags sampled at the rising edge, used at the falling edge
  logic in_xfer  = 1'b0;
  logic out_xfer = 1'b0;

  int unsigned words_queued   = 0;
  int unsigned words_accepted = 0;
  int unsigned instrs_seen    = 0;
  int unsigned comp_count     = 0;
  int unsigned straddle_count = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  // Split one word into instructions and advance the shadow state
  function automatic void align_word(input logic [ipa_pkg::WORD_BITS-1:0] word);
    logic [ipa_pkg::PARCEL_BITS-1:0] lo;
    logic [ipa_pkg::PARCEL_BITS-1:0] hi;
    ipa_pkg::half_addr_t             base;
    aligned_instr_t                  r;
    logic                            whole;
    lo    = word[ipa_pkg::PARCEL_BITS-1:0];
    hi    = word[ipa_pkg::WORD_BITS-1:ipa_pkg::PARCEL_BITS];
    base  = {fetch_index, 1'b0};
    whole = !held_valid && (lo[1:0] == ipa_pkg::OPEN32_CODE);
    r.last = 1'b0;
    if (held_valid) begin
      // low half completes the parcel held from the previous word
      r.instr   = {lo, held_parcel};
      r.is_comp = 1'b0;
      r.addr    = ipa_pkg::out_addr_t'(base - 1'b1);
      straddle_count++;
    end else if (whole) begin
      r.instr   = word;
      r.is_comp = 1'b0;
      r.addr    = ipa_pkg::out_addr_t'(base);
    end else begin
      r.instr   = {{ipa_pkg::PARCEL_BITS{1'b0}}, lo};
      r.is_comp = 1'b1;
      r.addr    = ipa_pkg::out_addr_t'(base);
      comp_count++;
    end
    if (whole) begin
      held_valid = 1'b0;
      r.last     = 1'b1;
      expected_instrs.insert(expected_instrs.size(), r);
    end else if (hi[1:0] == ipa_pkg::OPEN32_CODE) begin
      // upper half opens a 32-bit instruction: hold it, no result yet
      held_valid  = 1'b1;
      held_parcel = hi;
      r.last      = 1'b1;
      expected_instrs.insert(expected_instrs.size(), r);
    end else begin
      held_valid = 1'b0;
      expected_instrs.insert(expected_instrs.size(), r);
      r.instr   = {{ipa_pkg::PARCEL_BITS{1'b0}}, hi};
      r.is_comp = 1'b1;
      r.addr    = ipa_pkg::out_addr_t'(base + 1'b1);
      r.last    = 1'b1;
      expected_instrs.insert(expected_instrs.size(), r);
      comp_count++;
    end
    fetch_index = fetch_index + 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Monitor: check the output transfer first, then predict from the input transfer
  always @(posedge clk) begin
    aligned_instr_t want;
    if (!rst_n) begin
      in_xfer  = 1'b0;
      out_xfer = 1'b0;
    end else begin
      out_xfer = out_tvalid && out_tready;
      if (out_xfer) begin
        instrs_seen++;
        if (expected_instrs.size() == 0) begin
          $error("instruction %h at halfword %h with none expected",
                 out_tdata[ipa_pkg::INSTR_BITS-1:0],
                 out_tdata[ipa_pkg::INSTR_BITS +: ipa_pkg::OUT_ADDR_BITS]);
          fail_count++;
        end else begin
          want = expected_instrs.pop_front();
          check_field("instr", want.instr, out_tdata[ipa_pkg::INSTR_BITS-1:0]);
          check_field("halfword_addr", 32'(want.addr),
                      32'(out_tdata[ipa_pkg::INSTR_BITS +: ipa_pkg::OUT_ADDR_BITS]));
          check_field("is_compressed", 32'(want.is_comp), 32'(out_tuser));
          check_field("last", 32'(want.last), 32'(out_tlast));
        end
      end
      in_xfer = in_tvalid && in_tready;
      if (in_xfer) begin
        align_word(in_tdata);
        words_accepted++;
      end
    end
  end

  // Sender: hold the word until it transfers, then idle for its gap
  logic [3:0] send_gap = '0;
  always @(negedge clk) begin
    fetch_item_t item;
    if (rst_n && !(in_tvalid && !in_xfer)) begin
      if (send_gap != 0) begin
        send_gap  = send_gap - 1'b1;
        in_tvalid <= 1'b0;
      end else if (fetch_words.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        item      = fetch_words.pop_front();
        in_tdata  <= item.word;
        in_tvalid <= 1'b1;
        send_gap  = item.gap;
      end
    end
  end

  // Receiver: random stall after each transfer, quiet stretches, one long hold-off
  int unsigned rx_stall    = 0;
  int unsigned rx_hold     = 0;
  logic        rx_quiet    = 1'b0;
  logic        hold_issued = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_xfer) begin
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        rx_stall = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (!hold_issued && instrs_seen >= HOLD_AT_RESULT) begin
        rx_hold     = LONG_HOLD;
        hold_issued = 1'b1;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void queue_word(input logic [ipa_pkg::WORD_BITS-1:0] word,
                                     input int unsigned gap);
    fetch_item_t item;
    item.word = word;
    item.gap  = gap[3:0];
    fetch_words.insert(fetch_words.size(), item);
    words_queued++;
  endfunction

  // Random word; each half is forced to open a 32-bit instruction half the time, plus all-zero and all-one words
  function automatic logic [ipa_pkg::WORD_BITS-1:0] rand_word();
    logic [ipa_pkg::WORD_BITS-1:0] w;
    w = $urandom;
    if ($urandom_range(0, 1) == 0) w[1:0] = ipa_pkg::OPEN32_CODE;
    if ($urandom_range(0, 1) == 0) w[ipa_pkg::PARCEL_BITS +: 2] = ipa_pkg::OPEN32_CODE;
    case ($urandom_range(0, 31))
      0: w = '0;
      1: w = '1;
      default: ;
    endcase
    return w;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (words_accepted != words_queued || expected_instrs.size() != 0);
  endtask

  initial begin
    logic [ipa_pkg::WORD_BITS-1:0] directed [$];
    logic                          burst;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, whole words, held upper halves, chained straddles
    directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0001, 32'h0000_0002,
                 32'h7FFF_1234, 32'h0003_ABCD, 32'hFFFF_8003, 32'h5556_AAAA,
                 32'h8000_FFFE, 32'h0001_FFFD, 32'h1234_5677, 32'hAAAA_5555,
                 32'h5555_AAAB, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0000_0003};
    foreach (directed[i]) queue_word(directed[i], $urandom_range(0, 15));

    // Sender pauses until every instruction is out
    wait_drained();

    // Random words, with bursts that have no gaps
    burst = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % BURST_LEN == 0) burst = ($urandom_range(0, 3) == 0);
      queue_word(rand_word(), burst ? 0 : $urandom_range(0, 15));
    end
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d words and %0d instructions: %0d compressed, %0d straddling,",
             words_accepted, instrs_seen, comp_count, straddle_count);
    $display("with gapped and gap-free word streams and one long receiver hold-off.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ipa_pkg.sv
rtl/core/ipa_front.sv
rtl/core/ipa_queue.sv
rtl/core/ipa_back.sv
rtl/core/instruction_parcel_aligner.sv
bench/instruction_parcel_aligner_tb.sv
